// ----- src/vpa_pkg.sv -----
// Shared types and codes for the variable partition allocator.
package vpa_pkg;
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_FIT   = 3'd1;
  localparam logic [2:0] ST_UNKNOWN  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_ZERO     = 3'd4;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic CFG_MEM_SIZE = 1'b0;
  localparam logic CFG_POLICY   = 1'b1;

  localparam logic [15:0] DEFAULT_MEM = 16'd1024;

  // Width of block addresses kept in the tables.
  localparam int ADDR_WIDTH = 16;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture a request
    logic scan_g;     // step through grant records
    logic scan_f;     // step through free entries
    logic clr_idx;    // restart the scan index
    logic commit;     // apply the update and build the result
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic g_last;
    logic f_last;
  } sts_t;
endpackage

// ----- src/variable_partition_allocator.sv -----
// Top level of the variable partition allocator.
// Requests are handled one at a time, each by a sequential walk over the grant
// records and then the free entries; in_tready is high only in the idle state.
// Reset (synchronous, rst_n low): one free block [0, 1024), no grants, id counter at 1.
// A new request is taken while the previous result still waits in the output register.
module variable_partition_allocator #(
  parameter int GRANT_DEPTH = 16,
  parameter int FREE_DEPTH  = 17
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // req_size[15:0], release_id[31:16]
  input  logic        in_tuser,    // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // status[2:0], granted_id[18:3], block_address[34:19],
                                   // block_size[50:35], zero pad
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import vpa_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic idle;
  logic in_fire;
  logic [2:0] st;
  logic [15:0] rid, radr, rlen;
  logic out_v_r;

  // The controller accepts a request only in its idle state; the result register
  // frees the datapath as soon as the result is committed, before it is handed over.
  assign in_tready = idle;
  assign in_fire = in_tvalid && in_tready;

  vpa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
    .out_busy(out_v_r && !out_tready), .sts(sts), .cmd(cmd), .idle(idle)
  );

  vpa_dp #(.GRANT_DEPTH(GRANT_DEPTH), .FREE_DEPTH(FREE_DEPTH))
  u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_func(in_tuser), .in_size(in_tdata[15:0]), .in_id(in_tdata[31:16]),
    .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
    .res_status(st), .res_id(rid), .res_addr(radr), .res_len(rlen)
  );

  // The result becomes visible the cycle after commit and holds until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (cmd.commit) out_v_r <= 1'b1;
    else if (out_tready) out_v_r <= 1'b0;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = {5'd0, rlen, radr, rid, st};
endmodule

// ----- src/vpa_ctrl.sv -----
// Sequencer that walks the grant records and free entries for one request.
module vpa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic          out_busy,
  input  vpa_pkg::sts_t sts,
  output vpa_pkg::cmd_t cmd,
  output logic          idle
);
  import vpa_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GSCN = 3'd1;
  localparam logic [2:0] S_FSCN = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    idle = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          cmd.clr_idx = 1'b1;
          state_nxt = S_GSCN;
        end
      end
      S_GSCN: begin
        cmd.scan_g = 1'b1;
        if (sts.g_last) begin
          cmd.clr_idx = 1'b1;
          state_nxt = S_FSCN;
        end
      end
      S_FSCN: begin
        cmd.scan_f = 1'b1;
        if (sts.f_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd.commit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule

// ----- src/vpa_dp.sv -----
// Tables, scan registers and update logic of the allocator.
module vpa_dp #(
  parameter int GRANT_DEPTH = 16,
  parameter int FREE_DEPTH  = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  vpa_pkg::cmd_t cmd,
  output vpa_pkg::sts_t sts,
  input  logic          in_func,
  input  logic [15:0]   in_size,
  input  logic [15:0]   in_id,
  input  logic          cfg_we,
  input  logic          cfg_idx,
  input  logic [15:0]   cfg_data,
  output logic [2:0]    res_status,
  output logic [15:0]   res_id,
  output logic [15:0]   res_addr,
  output logic [15:0]   res_len
);
  import vpa_pkg::*;
  localparam int GW = (GRANT_DEPTH > 1) ? $clog2(GRANT_DEPTH) : 1;
  localparam int FW = $clog2(FREE_DEPTH);
  localparam int IW = ((GW > FW) ? GW : FW) + 1;

  logic [ADDR_WIDTH-1:0] fs_r [FREE_DEPTH];
  logic [15:0]           fl_r [FREE_DEPTH];
  logic [FREE_DEPTH-1:0] fv_r;
  logic [15:0]           go_r [GRANT_DEPTH];
  logic [ADDR_WIDTH-1:0] gs_r [GRANT_DEPTH];
  logic [15:0]           gl_r [GRANT_DEPTH];
  logic [GRANT_DEPTH-1:0] gv_r;
  logic [15:0] nid_r;
  logic        lock_r;
  logic [1:0]  pol_r;

  logic        func_r;
  logic [15:0] size_r, id_r;
  logic [IW-1:0] idx_r;
  logic        slot_ok_r, rec_ok_r, best_ok_r, prev_ok_r, next_ok_r, emp_ok_r;
  logic [GW-1:0] slot_r, rec_r;
  logic [FW-1:0] best_r, prev_r, next_r, emp_r;
  logic [ADDR_WIDTH-1:0] bst_r, rst_st_r, rend_r;
  logic [15:0] bln_r, rln_r;
  logic [2:0]  status_nxt;

  logic [GW-1:0] gi;
  logic [FW-1:0] fi;
  assign gi = idx_r[GW-1:0];
  assign fi = idx_r[FW-1:0];
  assign sts.g_last = (idx_r == IW'(GRANT_DEPTH - 1));
  assign sts.f_last = (idx_r == IW'(FREE_DEPTH - 1));

  logic take;
  always_comb begin
    take = 1'b0;
    if (fv_r[fi] && fl_r[fi] >= size_r) begin
      if (!best_ok_r) take = 1'b1;
      else if (pol_r == POL_BEST)
        take = fl_r[fi] < bln_r || (fl_r[fi] == bln_r && fs_r[fi] < bst_r);
      else if (pol_r == POL_WORST)
        take = fl_r[fi] > bln_r || (fl_r[fi] == bln_r && fs_r[fi] < bst_r);
      else take = fs_r[fi] < bst_r;
    end
  end

  logic [ADDR_WIDTH-1:0] fend;
  assign fend = fs_r[fi] + ADDR_WIDTH'(fl_r[fi]);

  // Outcome of the request once both scans are complete.
  always_comb begin
    status_nxt = ST_OK;
    if (!func_r) begin
      if (size_r == 16'd0) status_nxt = ST_ZERO;
      else if (!slot_ok_r) status_nxt = ST_FULL;
      else if (!best_ok_r) status_nxt = ST_NO_FIT;
    end else begin
      if (!rec_ok_r) status_nxt = ST_UNKNOWN;
      else if (!prev_ok_r && !next_ok_r && !emp_ok_r) status_nxt = ST_FULL;
    end
  end

  // scan
  always_ff @(posedge clk) begin
    if (cmd.clr_idx) idx_r <= '0;
    else if (cmd.scan_g || cmd.scan_f) idx_r <= idx_r + IW'(1);
    if (cmd.load) begin
      func_r <= in_func; size_r <= in_size; id_r <= in_id;
      slot_ok_r <= 1'b0; rec_ok_r <= 1'b0; best_ok_r <= 1'b0;
      prev_ok_r <= 1'b0; next_ok_r <= 1'b0; emp_ok_r <= 1'b0;
    end
    if (cmd.scan_g) begin
      if (!gv_r[gi] && !slot_ok_r) begin slot_ok_r <= 1'b1; slot_r <= gi; end
      if (gv_r[gi] && go_r[gi] == id_r && !rec_ok_r) begin
        rec_ok_r <= 1'b1; rec_r <= gi;
        rst_st_r <= gs_r[gi]; rln_r <= gl_r[gi];
        rend_r <= gs_r[gi] + ADDR_WIDTH'(gl_r[gi]);
      end
    end
    if (cmd.scan_f) begin
      if (take) begin
        best_ok_r <= 1'b1; best_r <= fi; bst_r <= fs_r[fi]; bln_r <= fl_r[fi];
      end
      if (!fv_r[fi]) begin
        if (!emp_ok_r) begin emp_ok_r <= 1'b1; emp_r <= fi; end
      end else if (fend == rst_st_r && !prev_ok_r) begin
        prev_ok_r <= 1'b1; prev_r <= fi;
      end else if (fs_r[fi] == rend_r && !next_ok_r) begin
        next_ok_r <= 1'b1; next_r <= fi;
      end
    end
  end

  // tables and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= FREE_DEPTH'(1);
      fs_r[0] <= '0; fl_r[0] <= DEFAULT_MEM;
      gv_r <= '0; nid_r <= 16'd1; lock_r <= 1'b0; pol_r <= POL_FIRST;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_POLICY) pol_r <= cfg_data[1:0];
        else if (!lock_r) begin
          fv_r <= {{(FREE_DEPTH-1){1'b0}}, (cfg_data != 16'd0)};
          fs_r[0] <= '0; fl_r[0] <= cfg_data;
        end
      end
      if (cmd.commit) begin
        res_status <= status_nxt;
        if (status_nxt != ST_OK) begin
          res_id <= 16'd0; res_addr <= 16'd0; res_len <= 16'd0;
        end else if (!func_r) begin
          fs_r[best_r] <= bst_r + ADDR_WIDTH'(size_r);
          fl_r[best_r] <= bln_r - size_r;
          if (bln_r == size_r) fv_r[best_r] <= 1'b0;
          go_r[slot_r] <= nid_r; gs_r[slot_r] <= bst_r; gl_r[slot_r] <= size_r;
          gv_r[slot_r] <= 1'b1; lock_r <= 1'b1;
          res_id <= nid_r; res_addr <= 16'(bst_r); res_len <= size_r;
          nid_r <= (nid_r == 16'hFFFF) ? 16'd1 : nid_r + 16'd1;
        end else begin
          if (prev_ok_r && next_ok_r) begin
            fl_r[prev_r] <= fl_r[prev_r] + rln_r + fl_r[next_r];
            fv_r[next_r] <= 1'b0;
          end else if (prev_ok_r) fl_r[prev_r] <= fl_r[prev_r] + rln_r;
          else if (next_ok_r) begin
            fs_r[next_r] <= rst_st_r; fl_r[next_r] <= fl_r[next_r] + rln_r;
          end else begin
            fs_r[emp_r] <= rst_st_r; fl_r[emp_r] <= rln_r; fv_r[emp_r] <= 1'b1;
          end
          gv_r[rec_r] <= 1'b0;
          res_id <= id_r; res_addr <= 16'(rst_st_r); res_len <= rln_r;
        end
      end
    end
  end
endmodule

// ----- src/vpa_checker.sv -----
// Port-level checker for the allocator, bound to the top level.
module vpa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);
  import vpa_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request accepted while busy");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != ST_OK |-> out_tdata[50:3] == 48'd0)
    else $error("error result carries data");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= ST_ZERO)
    else $error("bad status code");
endmodule

bind variable_partition_allocator vpa_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
